[hdl/ise_pkg.sv]
`default_nettype none

package ise_pkg;

    localparam int DATA_W = 32;

    typedef logic signed [DATA_W-1:0] data_t;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic  insert;
        logic  drain;
        data_t value;
    } ise_ctrl_t;

endpackage

`default_nettype wire

[hdl/insertion_sort_engine.sv]
`default_nettype none

// Stable ascending sort of one run of signed 32-bit values in a chain of
// MAX_ELEMENTS compare-and-shift cells. While busy is low one item is taken in
// every cycle that start is high; it is inserted in that cycle. An item with
// end_of_run set starts the output: busy, driven by drain_reg, stays high
// while the chain drains. The n results, n being the number of stored values,
// are registered and appear on consecutive cycles, each marked by result_valid
// for exactly one cycle, with last_of_run on the final one, as the chain shifts
// out one cell per cycle. A new run may start in the cycle that shows the last
// result. Items that arrive while all cells are full are dropped and every
// result of that run carries overflowed. The receiver cannot stall.
module insertion_sort_engine #(
    parameter int MAX_ELEMENTS = 16
) (
    input  wire            clk,
    input  wire            rst_n,
    input  wire            start,
    output logic           busy,
    input  ise_pkg::data_t value,
    input  wire            end_of_run,
    output logic           result_valid,
    output ise_pkg::data_t sorted_value,
    output logic           last_of_run,
    output logic           overflowed
);
    import ise_pkg::*;

    data_t     cell_value   [MAX_ELEMENTS];
    logic      cell_valid   [MAX_ELEMENTS];
    logic      cell_greater [MAX_ELEMENTS];
    ise_ctrl_t ctrl;
    logic      accept;
    logic      full;
    logic      drain_done;

    logic  drain_reg;
    logic  drain_next;
    logic  drop_reg;
    logic  drop_next;
    logic  result_valid_reg;
    logic  result_valid_next;
    data_t sorted_value_reg;
    logic  last_reg;
    logic  overflowed_reg;

    assign accept     = start && !drain_reg;
    assign full       = cell_valid[MAX_ELEMENTS-1];
    assign drain_done = drain_reg && !cell_valid[1];

    assign ctrl = '{insert: accept && !full, drain: drain_reg, value: value};

    genvar i;
    generate
        for (i = 0; i < MAX_ELEMENTS; i++)
        begin : g_cell
            data_t lv;
            logic  lvalid;
            logic  lgreater;
            data_t rv;
            logic  rvalid;

            if (i == 0)
            begin : g_first
                assign lv       = '0;
                assign lvalid   = 1'b1;
                assign lgreater = 1'b0;
            end
            else
            begin : g_mid_l
                assign lv       = cell_value[i-1];
                assign lvalid   = cell_valid[i-1];
                assign lgreater = cell_greater[i-1];
            end

            if (i == MAX_ELEMENTS-1)
            begin : g_last
                assign rv     = '0;
                assign rvalid = 1'b0;
            end
            else
            begin : g_mid_r
                assign rv     = cell_value[i+1];
                assign rvalid = cell_valid[i+1];
            end

            ise_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctrl         (ctrl),
                .left_value   (lv),
                .left_valid   (lvalid),
                .left_greater (lgreater),
                .right_value  (rv),
                .right_valid  (rvalid),
                .value        (cell_value[i]),
                .valid        (cell_valid[i]),
                .greater      (cell_greater[i])
            );
        end
    endgenerate

    always_comb
    begin
        drain_next = drain_reg;
        if (accept && end_of_run)
        begin
            drain_next = 1'b1;
        end
        else if (drain_done)
        begin
            drain_next = 1'b0;
        end
    end

    always_comb
    begin
        drop_next = drop_reg;
        if (accept && full)
        begin
            drop_next = 1'b1;
        end
        else if (drain_done)
        begin
            drop_next = 1'b0;
        end
    end

    assign result_valid_next = drain_reg && cell_valid[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg        <= 1'b0;
            drop_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            drain_reg        <= drain_next;
            drop_reg         <= drop_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sorted_value_reg <= cell_value[0];
        last_reg         <= !cell_valid[1];
        overflowed_reg   <= drop_reg;
    end

    assign busy         = drain_reg;
    assign result_valid = result_valid_reg;
    assign sorted_value = sorted_value_reg;
    assign last_of_run  = last_reg;
    assign overflowed   = overflowed_reg;

endmodule

`default_nettype wire

[hdl/ise_cell.sv]
`default_nettype none

module ise_cell (
    input  wire               clk,
    input  wire               rst_n,
    input  ise_pkg::ise_ctrl_t ctrl,
    input  ise_pkg::data_t    left_value,
    input  wire               left_valid,
    input  wire               left_greater,
    input  ise_pkg::data_t    right_value,
    input  wire               right_valid,
    output ise_pkg::data_t    value,
    output logic              valid,
    output logic              greater
);
    import ise_pkg::*;

    data_t store_reg;
    data_t store_next;
    logic  valid_reg;
    logic  valid_next;

    assign greater = valid_reg && (store_reg > ctrl.value);
    assign value   = store_reg;
    assign valid   = valid_reg;

    always_comb
    begin
        store_next = store_reg;
        valid_next = valid_reg;
        if (ctrl.insert && (greater || (!valid_reg && left_valid)))
        begin
            // strictly greater entries move up, equal keys stay ahead
            store_next = left_greater ? left_value : ctrl.value;
            valid_next = 1'b1;
        end
        else if (ctrl.drain)
        begin
            store_next = right_value;
            valid_next = right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        store_reg <= store_next;
    end

endmodule

`default_nettype wire

[hdl/ise_checker.sv]
`default_nettype none

module ise_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire end_of_run,
    input wire result_valid,
    input wire last_of_run
);

    // results of one run come on consecutive cycles
    a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last_of_run |=> result_valid)
        else $error("gap inside the results of a run");

    a_eor_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && end_of_run |=> busy)
        else $error("end of run did not start output");

    a_last_free: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && last_of_run |-> !busy)
        else $error("busy still high with the final result");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without output phase");

endmodule

bind insertion_sort_engine ise_checker u_ise_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .end_of_run   (end_of_run),
    .result_valid (result_valid),
    .last_of_run  (last_of_run)
);

`default_nettype wire
